// File: rtl/nsd_pkg.sv
// Shared types, result codes and the symbol alphabet of the string decoder.
// No dependencies; every other design file but nsd_if imports this package.
package nsd_pkg;

   // Result kinds
   localparam logic [1:0] KIND_HEADER = 2'd0;
   localparam logic [1:0] KIND_DATA   = 2'd1;
   localparam logic [1:0] KIND_END    = 2'd2;

   // Header is nine bytes: CRC, four key bytes, four length bytes
   localparam logic [3:0] HDR_BYTES = 4'd9;

   // Symbol given to any character outside the alphabet
   localparam logic [5:0] SYM_INVALID = 6'd63;
   localparam logic [5:0] SYM_OPEN_BRACE = 6'd62;

   // One complete group of three bytes, or a bare end mark, as queued
   typedef struct packed {
      logic [23:0] bytes;
      logic        has_group;
      logic        last;
   } grp_type;

   // Payload of one result, without its last flag
   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  data_byte;
      logic [7:0]  crc;
      logic [31:0] key;
      logic [31:0] length;
      logic        truncated;
   } result_type;

   // Map the low seven bits of a character onto the 64-symbol alphabet
   function automatic logic [5:0] symbol_of(input logic [6:0] c);
      logic [5:0] s;
      if (c >= 7'h30 && c <= 7'h39) begin
         s = 6'(c - 7'd48);
      end else if (c >= 7'h41 && c <= 7'h5a) begin
         s = 6'(c - 7'd55);
      end else if (c >= 7'h61 && c <= 7'h7a) begin
         s = 6'(c - 7'd61);
      end else if (c == 7'h7b) begin
         s = SYM_OPEN_BRACE;
      end else begin
         s = SYM_INVALID;
      end
      return s;
   endfunction

endpackage

// File: rtl/nsd_if.sv
// Handshake channels of the string decoder: characters in, results out, register write.
// No dependencies.
interface nsd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       last;
   modport source(output valid, ch, last, input ready);
   modport sink(input valid, ch, last, output ready);
endinterface

interface nsd_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  data_byte;
   logic [7:0]  crc;
   logic [31:0] key;
   logic [31:0] length;
   logic        truncated;
   logic        last_result;
   modport source(output valid, kind, data_byte, crc, key, length, truncated, last_result,
                  input ready);
   modport sink(input valid, kind, data_byte, crc, key, length, truncated, last_result,
                output ready);
endinterface

interface nsd_csr_if;
   logic valid;
   logic ready;
   logic output_raw;
   modport source(output valid, output_raw, input ready);
   modport sink(input valid, output_raw, output ready);
endinterface

// File: rtl/nsd_front.sv
// Front end: accepts characters, maps them to symbols and packs four symbols into a group.
// Depends on nsd_pkg and nsd_req_if; feeds nsd_queue.
module nsd_front (
   input  logic             clock,
   input  logic             reset,
   nsd_req_if.sink          req_if,
   input  logic             q_full,
   output logic             push_valid,
   output nsd_pkg::grp_type push_data
);
   import nsd_pkg::*;

   logic [17:0] acc_ff, acc_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic [5:0]  sym;
   logic        take;

   assign req_if.ready = !q_full;
   assign take = req_if.valid && !q_full;
   assign sym  = symbol_of(req_if.ch[6:0]);

   // Collect symbols; close a group on the fourth, drop a partial group on last
   always_comb begin
      acc_in     = acc_ff;
      cnt_in     = cnt_ff;
      push_data  = '0;
      push_valid = 1'b0;
      if (take) begin
         if (cnt_ff != 2'd3) begin
            acc_in = {acc_ff[11:0], sym};
            cnt_in = cnt_ff + 2'd1;
         end else begin
            push_data.bytes     = {acc_ff, sym};
            push_data.has_group = 1'b1;
            acc_in              = '0;
            cnt_in              = '0;
         end
         if (req_if.last) begin
            push_data.last = 1'b1;
            acc_in         = '0;
            cnt_in         = '0;
         end
         push_valid = push_data.has_group || push_data.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         cnt_ff <= '0;
      end else begin
         acc_ff <= acc_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// File: rtl/nsd_queue.sv
// Short FIFO of byte groups between the front end and the byte sequencer.
// Depends on nsd_pkg.
module nsd_queue #(
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  nsd_pkg::grp_type push_data,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output nsd_pkg::grp_type head_data
);
   import nsd_pkg::*;

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   grp_type         entry_ff [DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push;

   assign full       = (count_ff == CntW'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && !full;

   // Track fill level
   always_comb begin
      case ({do_push, pop})
         2'b10:   count_in = count_ff + CntW'(1);
         2'b01:   count_in = count_ff - CntW'(1);
         default: count_in = count_ff;
      endcase
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Advance pointers with wrap
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
         end
      end
   end

endmodule

// File: rtl/nsd_back.sv
// Back end: walks the bytes of each queued group, parses the header, converts the
// payload and emits its results in order. Depends on nsd_pkg and nsd_rsp_if.
module nsd_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             output_raw,
   input  logic             head_valid,
   input  nsd_pkg::grp_type head_data,
   output logic             pop,
   nsd_rsp_if.source        rsp_if
);
   import nsd_pkg::*;

   localparam logic [15:0] UTF8_MAX1 = 16'h007f;
   localparam logic [15:0] UTF8_MAX2 = 16'h07ff;
   localparam logic [7:0]  LEAD2     = 8'hc0;
   localparam logic [7:0]  LEAD3     = 8'he0;
   localparam logic [7:0]  CONT      = 8'h80;
   localparam logic [1:0]  BIDX_DONE = 2'd3;

   // Sequencer and decoder state
   logic [1:0]  bidx_ff, bidx_in;
   logic [1:0]  usub_ff, usub_in;
   logic [15:0] u_ff, u_in;
   logic [3:0]  hpos_ff, hpos_in;
   logic [7:0]  crc_ff, crc_in;
   logic [31:0] key_ff, key_in;
   logic [31:0] len_ff, len_in;
   logic [31:0] rem_ff, rem_in;
   logic [7:0]  low_ff, low_in;
   logic        have_low_ff, have_low_in;

   // Staging slot (holds a result until its last flag is known) and output register
   logic        s_valid_ff, s_valid_in;
   logic        s_final_ff, s_final_in;
   result_type  s_res_ff, s_res_in;
   logic        o_valid_ff, o_valid_in;
   logic        o_last_ff, o_last_in;
   result_type  o_res_ff, o_res_in;

   logic        o_free, adv, gen, gen_end, pop_nolast, s_move;
   logic [7:0]  cur_byte;
   logic [15:0] unit;
   result_type  res;

   assign o_free = !o_valid_ff || rsp_if.ready;
   assign adv    = head_valid && (!s_valid_ff || o_free);
   assign unit   = {cur_byte, low_ff};

   // Pick the byte of the group under work, most significant first
   always_comb begin
      case (bidx_ff)
         2'd0:    cur_byte = head_data.bytes[23:16];
         2'd1:    cur_byte = head_data.bytes[15:8];
         default: cur_byte = head_data.bytes[7:0];
      endcase
   end

   // One step per unstalled cycle: pending UTF-8 byte, next group byte, or close entry
   always_comb begin
      bidx_in     = bidx_ff;
      usub_in     = usub_ff;
      u_in        = u_ff;
      hpos_in     = hpos_ff;
      crc_in      = crc_ff;
      key_in      = key_ff;
      len_in      = len_ff;
      rem_in      = rem_ff;
      low_in      = low_ff;
      have_low_in = have_low_ff;
      gen         = 1'b0;
      gen_end     = 1'b0;
      pop         = 1'b0;
      pop_nolast  = 1'b0;
      res         = '0;
      if (adv) begin
         if (usub_ff != 2'd0) begin
            // Continuation bytes of a multi-byte sequence
            gen       = 1'b1;
            res.kind  = KIND_DATA;
            res.data_byte = (usub_ff == 2'd2) ? (CONT | {2'b00, u_ff[11:6]})
                                              : (CONT | {2'b00, u_ff[5:0]});
            usub_in   = usub_ff - 2'd1;
         end else if (head_data.has_group && bidx_ff != BIDX_DONE) begin
            bidx_in = bidx_ff + 2'd1;
            if (hpos_ff != HDR_BYTES) begin
               // Header bytes
               case (hpos_ff)
                  4'd0:    crc_in        = cur_byte;
                  4'd1:    key_in[7:0]   = cur_byte;
                  4'd2:    key_in[15:8]  = cur_byte;
                  4'd3:    key_in[23:16] = cur_byte;
                  4'd4:    key_in[31:24] = cur_byte;
                  default: len_in        = {len_ff[23:0], cur_byte};
               endcase
               hpos_in = hpos_ff + 4'd1;
               if (hpos_ff == HDR_BYTES - 4'd1) begin
                  gen         = 1'b1;
                  res.kind    = KIND_HEADER;
                  res.crc     = crc_ff;
                  res.key     = key_ff;
                  res.length  = len_in;
                  rem_in      = len_in;
                  have_low_in = 1'b0;
               end
            end else if (rem_ff != '0) begin
               // Payload bytes; anything beyond the length is dropped
               rem_in = rem_ff - 32'd1;
               if (output_raw) begin
                  gen           = 1'b1;
                  res.kind      = KIND_DATA;
                  res.data_byte = cur_byte;
               end else if (!have_low_ff) begin
                  low_in      = cur_byte;
                  have_low_in = 1'b1;
               end else begin
                  have_low_in = 1'b0;
                  u_in        = unit;
                  gen         = 1'b1;
                  res.kind    = KIND_DATA;
                  if (unit <= UTF8_MAX1) begin
                     res.data_byte = unit[7:0];
                     usub_in       = 2'd0;
                  end else if (unit <= UTF8_MAX2) begin
                     res.data_byte = LEAD2 | {3'b000, unit[10:6]};
                     usub_in       = 2'd1;
                  end else begin
                     res.data_byte = LEAD3 | {4'b0000, unit[15:12]};
                     usub_in       = 2'd2;
                  end
               end
            end
         end else begin
            // Close the entry; on last emit the end result and clear the decoder
            pop     = 1'b1;
            bidx_in = '0;
            if (head_data.last) begin
               gen           = 1'b1;
               gen_end       = 1'b1;
               res.kind      = KIND_END;
               res.truncated = (hpos_ff != HDR_BYTES) || (rem_ff != '0);
               hpos_in       = '0;
               crc_in        = '0;
               key_in        = '0;
               len_in        = '0;
               rem_in        = '0;
               low_in        = '0;
               have_low_in   = 1'b0;
            end else begin
               pop_nolast = 1'b1;
            end
         end
      end
   end

   // Move the staged result out once its last flag is settled
   always_comb begin
      s_move     = s_valid_ff && o_free && (s_final_ff || gen || pop_nolast);
      o_valid_in = o_valid_ff;
      o_last_in  = o_last_ff;
      o_res_in   = o_res_ff;
      s_valid_in = s_valid_ff;
      s_final_in = s_final_ff;
      s_res_in   = s_res_ff;
      if (s_move) begin
         o_valid_in = 1'b1;
         o_res_in   = s_res_ff;
         o_last_in  = s_final_ff || pop_nolast;
      end else if (rsp_if.ready) begin
         o_valid_in = 1'b0;
      end
      if (gen) begin
         s_valid_in = 1'b1;
         s_res_in   = res;
         s_final_in = gen_end;
      end else if (s_move) begin
         s_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bidx_ff     <= '0;
         usub_ff     <= '0;
         hpos_ff     <= '0;
         crc_ff      <= '0;
         key_ff      <= '0;
         len_ff      <= '0;
         rem_ff      <= '0;
         low_ff      <= '0;
         have_low_ff <= 1'b0;
         s_valid_ff  <= 1'b0;
         s_final_ff  <= 1'b0;
         o_valid_ff  <= 1'b0;
         o_last_ff   <= 1'b0;
      end else begin
         bidx_ff     <= bidx_in;
         usub_ff     <= usub_in;
         hpos_ff     <= hpos_in;
         crc_ff      <= crc_in;
         key_ff      <= key_in;
         len_ff      <= len_in;
         rem_ff      <= rem_in;
         low_ff      <= low_in;
         have_low_ff <= have_low_in;
         s_valid_ff  <= s_valid_in;
         s_final_ff  <= s_final_in;
         o_valid_ff  <= o_valid_in;
         o_last_ff   <= o_last_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      u_ff     <= u_in;
      s_res_ff <= s_res_in;
      o_res_ff <= o_res_in;
   end

   assign rsp_if.valid       = o_valid_ff;
   assign rsp_if.kind        = o_res_ff.kind;
   assign rsp_if.data_byte   = o_res_ff.data_byte;
   assign rsp_if.crc         = o_res_ff.crc;
   assign rsp_if.key         = o_res_ff.key;
   assign rsp_if.length      = o_res_ff.length;
   assign rsp_if.truncated   = o_res_ff.truncated;
   assign rsp_if.last_result = o_last_ff;

endmodule

// File: rtl/nsc_string_decoder.sv
// Top level of the encoded station-string decoder.
// Depends on nsd_pkg, nsd_if, nsd_front, nsd_queue and nsd_back.
//
// Usage:
//   req_if  - one character per item (ch, last). last ends the string.
//   rsp_if  - results: header (kind 0), payload/UTF-8 byte (kind 1), end (kind 2).
//             last_result marks the final result caused by one character.
//   csr_if  - writes output_raw (1 = raw payload, 0 = UTF-16LE to UTF-8).
//             Always ready; write only while the decoder is idle.
// Path: the results of a character pass through the queue, the staging slot and
//   the output register before they appear on rsp_if.
// Throughput: characters are taken one per cycle while the queue has room.
//   The byte sequencer takes a step for each byte of a group, for each extra
//   UTF-8 byte and to close each queued group.
// Reset: clears the decoder, the queue and output_raw.
// Stall: when rsp_if.ready is low the output register holds; the queue
//   keeps absorbing characters until it fills, then req_if.ready drops.
module nsc_string_decoder #(
   parameter int QUEUE_DEPTH = 4
) (
   input logic        clock,
   input logic        reset,
   nsd_req_if.sink    req_if,
   nsd_rsp_if.source  rsp_if,
   nsd_csr_if.sink    csr_if
);
   import nsd_pkg::*;

   logic    output_raw_ff;
   logic    push_valid, q_full, head_valid, pop;
   grp_type push_data, head_data;

   // Register write
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         output_raw_ff <= 1'b0;
      end else if (csr_if.valid) begin
         output_raw_ff <= csr_if.output_raw;
      end
   end

   nsd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .q_full     (q_full),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   nsd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   nsd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .output_raw (output_raw_ff),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop),
      .rsp_if     (rsp_if)
   );

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench of the encoded station-string decoder nsc_string_decoder.
// Depends on nsd_pkg and the channel interfaces of nsd_if; predicts every result
// of each accepted character and checks the result channel against it.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import nsd_pkg::*;

   localparam int CLK_HALF      = 5;
   localparam int RESET_CYCLES  = 10;
   localparam int SETTLE_CYCLES = 48;
   localparam int TIMEOUT_NS    = 2_000_000;
   localparam int PHASE_CHARS   = 6;

   // One predicted result with its end-of-step flag
   typedef struct {
      result_type body;
      logic       last_result;
   } decoded_result_type;

   logic clock = 1'b0;
   logic reset;

   nsd_req_if req_if();
   nsd_rsp_if rsp_if();
   nsd_csr_if csr_if();

   nsc_string_decoder DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   always #CLK_HALF clock = ~clock;

   // Decoder state as predicted
   logic [17:0] dec_acc;
   logic [1:0]  dec_syms;
   logic [3:0]  hdr_count;
   logic [7:0]  hdr_crc;
   logic [31:0] hdr_key;
   logic [31:0] hdr_len;
   logic [31:0] bytes_left;
   logic [7:0]  utf_low;
   logic        utf_low_valid;
   logic        raw_mode;

   decoded_result_type decoded_q[$];
   logic [7:0]         stream_bytes[$];

   int   err_count       = 0;
   int   chars_sent      = 0;
   int   sender_idle_pct = 0;
   int   rsp_stall_pct   = 0;
   int   rsp_hold_left   = 0;
   logic req_up          = 1'b0;

   // ---------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------

   function automatic logic [5:0] char_symbol(input logic [7:0] c);
      logic [6:0] a;
      a = c[6:0];
      if (a >= 7'h30 && a <= 7'h39) return 6'(a - 7'h30);
      if (a >= 7'h41 && a <= 7'h5a) return 6'(a - 7'h41 + 7'd10);
      if (a >= 7'h61 && a <= 7'h7a) return 6'(a - 7'h61 + 7'd36);
      if (a == 7'h7b) return SYM_OPEN_BRACE;
      return SYM_INVALID;
   endfunction

   function automatic void push_result(input logic [1:0] kind, input logic [7:0] data,
                                       input logic [7:0] crc, input logic [31:0] key,
                                       input logic [31:0] len, input logic trunc);
      decoded_result_type r;
      r.body.kind      = kind;
      r.body.data_byte = data;
      r.body.crc       = crc;
      r.body.key       = key;
      r.body.length    = len;
      r.body.truncated = trunc;
      r.last_result    = 1'b0;
      decoded_q.push_back(r);
   endfunction

   function automatic void clear_string_state();
      dec_acc       = '0;
      dec_syms      = '0;
      hdr_count     = '0;
      hdr_crc       = '0;
      hdr_key       = '0;
      hdr_len       = '0;
      bytes_left    = '0;
      utf_low       = '0;
      utf_low_valid = 1'b0;
   endfunction

   // Expand one UTF-16 unit into its UTF-8 bytes
   function automatic void emit_utf8(input logic [15:0] u);
      if (u <= 16'h007f) begin
         push_result(KIND_DATA, u[7:0], '0, '0, '0, 1'b0);
      end else if (u <= 16'h07ff) begin
         push_result(KIND_DATA, 8'hc0 | {3'b000, u[10:6]}, '0, '0, '0, 1'b0);
         push_result(KIND_DATA, 8'h80 | {2'b00, u[5:0]}, '0, '0, '0, 1'b0);
      end else begin
         push_result(KIND_DATA, 8'he0 | {4'h0, u[15:12]}, '0, '0, '0, 1'b0);
         push_result(KIND_DATA, 8'h80 | {2'b00, u[11:6]}, '0, '0, '0, 1'b0);
         push_result(KIND_DATA, 8'h80 | {2'b00, u[5:0]}, '0, '0, '0, 1'b0);
      end
   endfunction

   // Route one decoded byte to the header or the payload
   function automatic void take_byte(input logic [7:0] b);
      if (hdr_count < HDR_BYTES) begin
         if (hdr_count == 0)
            hdr_crc = b;
         else if (hdr_count <= 4)
            hdr_key = hdr_key | (32'(b) << (8 * (hdr_count - 1)));
         else
            hdr_len = {hdr_len[23:0], b};
         hdr_count++;
         if (hdr_count == HDR_BYTES) begin
            push_result(KIND_HEADER, '0, hdr_crc, hdr_key, hdr_len, 1'b0);
            bytes_left    = hdr_len;
            utf_low_valid = 1'b0;
         end
         return;
      end
      // bytes beyond the announced length are dropped
      if (bytes_left == 0) return;
      bytes_left--;
      if (raw_mode) begin
         push_result(KIND_DATA, b, '0, '0, '0, 1'b0);
      end else if (!utf_low_valid) begin
         utf_low       = b;
         utf_low_valid = 1'b1;
      end else begin
         emit_utf8({b, utf_low});
         utf_low_valid = 1'b0;
      end
   endfunction

   function automatic void decode_char(input logic [7:0] c, input logic fin);
      logic [5:0]  sym;
      logic [23:0] grp;
      int          base;
      base = decoded_q.size();
      sym  = char_symbol(c);
      if (dec_syms < 3) begin
         dec_acc = {dec_acc[11:0], sym};
         dec_syms++;
      end else begin
         grp      = {dec_acc, sym};
         dec_acc  = '0;
         dec_syms = '0;
         take_byte(grp[23:16]);
         take_byte(grp[15:8]);
         take_byte(grp[7:0]);
      end
      // a partial group is simply lost when the string ends
      if (fin) begin
         push_result(KIND_END, '0, '0, '0, '0, (hdr_count < HDR_BYTES) || (bytes_left != 0));
         clear_string_state();
      end
      if (decoded_q.size() > base) decoded_q[$].last_result = 1'b1;
   endfunction

   // ---------------------------------------------------------------
   // Result side: check, then decide ready for the next cycle
   // ---------------------------------------------------------------

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         err_count++;
      end
   endfunction

   always @(posedge clock) begin
      decoded_result_type want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (decoded_q.size() == 0) begin
            $error("result with nothing expected: kind %0d", rsp_if.kind);
            err_count++;
         end else begin
            want = decoded_q.pop_front();
            check_field("kind", want.body.kind, rsp_if.kind);
            check_field("data_byte", want.body.data_byte, rsp_if.data_byte);
            check_field("crc", want.body.crc, rsp_if.crc);
            check_field("key", want.body.key, rsp_if.key);
            check_field("length", want.body.length, rsp_if.length);
            check_field("truncated", want.body.truncated, rsp_if.truncated);
            check_field("last_result", want.last_result, rsp_if.last_result);
         end
      end
      // a long hold-off wins over the random stall
      if (rsp_hold_left > 0) begin
         rsp_if.ready <= 1'b0;
         rsp_hold_left--;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // ---------------------------------------------------------------
   // Character side
   // ---------------------------------------------------------------

   task automatic send_char(input logic [7:0] c, input logic fin);
      while ($urandom_range(99) < sender_idle_pct) begin
         if (req_up) begin
            req_if.valid <= 1'b0;
            req_up = 1'b0;
         end
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.ch    <= c;
      req_if.last  <= fin;
      req_up = 1'b1;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      decode_char(c, fin);
      chars_sent++;
   endtask

   // Pick a character for a symbol; bit 7 is noise the decoder must ignore
   function automatic logic [7:0] symbol_char(input logic [5:0] s);
      logic [6:0] a;
      if (s < 10)
         a = 7'(7'h30 + s);
      else if (s < 36)
         a = 7'(7'h41 + s - 10);
      else if (s < 62)
         a = 7'(7'h61 + s - 36);
      else if (s == SYM_OPEN_BRACE)
         a = 7'h7b;
      else begin
         a = 7'($urandom_range(127));
         while (char_symbol({1'b0, a}) != SYM_INVALID) a = 7'($urandom_range(127));
      end
      return {1'($urandom_range(1)), a};
   endfunction

   function automatic void push_header(input logic [7:0] crc, input logic [31:0] key,
                                       input logic [31:0] len);
      stream_bytes.push_back(crc);
      for (int i = 0; i < 4; i++) stream_bytes.push_back(key[8*i +: 8]);
      for (int i = 3; i >= 0; i--) stream_bytes.push_back(len[8*i +: 8]);
   endfunction

   // Encode the queued bytes as characters, add partial-group symbols, optionally end
   task automatic send_stream(input int tail, input bit close);
      logic [23:0] w;
      int          groups;
      int          n_tail;
      n_tail = tail;
      while (stream_bytes.size() % 3 != 0) stream_bytes.push_back(8'($urandom));
      if (close && stream_bytes.size() == 0 && n_tail == 0) n_tail = 1;
      groups = stream_bytes.size() / 3;
      for (int g = 0; g < groups; g++) begin
         w = {stream_bytes[3*g], stream_bytes[3*g+1], stream_bytes[3*g+2]};
         for (int j = 0; j < 4; j++)
            send_char(symbol_char(w[23-6*j -: 6]),
                      close && n_tail == 0 && g == groups - 1 && j == 3);
      end
      for (int k = 0; k < n_tail; k++)
         send_char(symbol_char(6'($urandom_range(63))), close && k == n_tail - 1);
      stream_bytes.delete();
   endtask

   // Drop valid, drain every expected result, then let the pipeline settle
   task automatic wait_idle();
      if (req_up) begin
         req_if.valid <= 1'b0;
         req_up = 1'b0;
      end
      while (decoded_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_output_raw(input logic v);
      csr_if.valid      <= 1'b1;
      csr_if.output_raw <= v;
      do @(posedge clock); while (csr_if.ready !== 1'b1);
      csr_if.valid <= 1'b0;
      raw_mode = v;
   endtask

   // Mostly well-formed strings with random content; some noise, cuts and huge lengths
   task automatic send_random_string();
      int          sel;
      int          plen;
      int          n;
      int          cut;
      logic [31:0] len;
      sel = $urandom_range(99);
      if (sel < 10) begin
         n = $urandom_range(1, 8);
         for (int i = 0; i < n; i++) send_char(8'($urandom), i == n - 1);
         return;
      end
      plen = $urandom_range(0, 8);
      len  = (sel < 25) ? 32'($urandom) : 32'(plen);
      push_header(8'($urandom), 32'($urandom), len);
      for (int i = 0; i < plen; i++) begin
         if (i % 2 == 0)
            stream_bytes.push_back(8'($urandom));
         else
            case ($urandom_range(3))
               0:       stream_bytes.push_back(8'h00);
               1:       stream_bytes.push_back(8'($urandom_range(1, 7)));
               default: stream_bytes.push_back(8'($urandom));
            endcase
      end
      n = $urandom_range(0, 4);
      for (int i = 0; i < n; i++) stream_bytes.push_back(8'($urandom));
      if (sel < 45) begin
         cut = $urandom_range(0, stream_bytes.size());
         while (stream_bytes.size() > cut) void'(stream_bytes.pop_back());
      end
      send_stream($urandom_range(0, 3), 1'b1);
   endtask

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------

   // All-ones CRC and key, 1/2/3-byte UTF-8 units, odd trailing byte, extra bytes, partial tail
   task automatic test_utf16_units();
      write_output_raw(1'b0);
      push_header(8'hff, 32'hffff_ffff, 32'd7);
      stream_bytes = {stream_bytes, 8'h7f, 8'h00, 8'hff, 8'h07, 8'hff, 8'hff, 8'h41,
                      8'h00, 8'h12};
      send_stream(1, 1'b1);
   endtask

   // Zero length with an all-zero header, then a string cut inside the header
   task automatic test_empty_and_cut_strings();
      push_header(8'h00, 32'h0, 32'h0);
      send_stream(0, 1'b1);
      send_stream(1, 1'b1);
   endtask

   // Switch to raw with a low byte pending; it must stay pending and then be dropped
   task automatic test_raw_switch_mid_string();
      wait_idle();
      write_output_raw(1'b0);
      push_header(8'h5a, 32'h1234_5678, 32'd6);
      stream_bytes = {stream_bytes, 8'h34, 8'h12, 8'h56};
      send_stream(0, 1'b0);
      wait_idle();
      write_output_raw(1'b1);
      stream_bytes = {8'h9a, 8'hbc, 8'hde};
      send_stream(0, 1'b1);
   endtask

   task automatic run_random_phase(input int idle_pct, input int stall_pct, input logic raw);
      int start;
      wait_idle();
      write_output_raw(raw);
      sender_idle_pct = idle_pct;
      rsp_stall_pct   = stall_pct;
      start           = chars_sent;
      while (chars_sent - start < PHASE_CHARS) send_random_string();
   endtask

   task automatic test_random_strings();
      run_random_phase(0, 0, 1'b0);
      run_random_phase(84, 0, 1'b1);
      run_random_phase(0, 84, 1'b0);
      run_random_phase(7, 7, 1'b1);
   endtask

   // Hold the result side off long enough for the queue to fill and stall the input
   task automatic test_result_backpressure();
      wait_idle();
      write_output_raw(1'b0);
      sender_idle_pct = 0;
      rsp_stall_pct   = 0;
      rsp_hold_left   = 200;
      push_header(8'($urandom), 32'($urandom), 32'd16);
      for (int i = 0; i < 16; i++) stream_bytes.push_back(8'($urandom));
      send_stream(0, 1'b1);
   endtask

   initial begin
      reset             = 1'b1;
      req_if.valid      = 1'b0;
      req_if.ch         = '0;
      req_if.last       = 1'b0;
      rsp_if.ready      = 1'b0;
      csr_if.valid      = 1'b0;
      csr_if.output_raw = 1'b0;
      raw_mode          = 1'b0;
      clear_string_state();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_utf16_units();
      test_empty_and_cut_strings();
      test_raw_switch_mid_string();
      test_random_strings();
      test_result_backpressure();

      wait_idle();
      if (err_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Hard stop if the run hangs
   initial begin
      #(TIMEOUT_NS);
      $display("*** FAILED ***");
      $finish;
   end

endmodule

// File: nsc_string_decoder.f
rtl/nsd_pkg.sv
rtl/nsd_if.sv
rtl/nsd_front.sv
rtl/nsd_queue.sv
rtl/nsd_back.sv
rtl/nsc_string_decoder.sv
tb/sv/tb_top.sv
